[hw/rtl/vrac_pkg.sv]
// Shared constants and the tone curve function for the voxel ray compositor.
package vrac_pkg;

  localparam int VOXEL_W   = 8;
  localparam int PIXEL_W   = 32;
  localparam int GRAY_W    = 8;
  localparam int QUEUE_DEPTH = 2;

  // Output scale: gray = floor(s * 25599 / (200 * ONE))
  localparam int SCALE_W      = 15;
  localparam logic [SCALE_W-1:0] GRAY_SCALE = 15'd25599;
  // Divide by 200*ONE: shift by FRAC_BITS+3, then divide by 25 via reciprocal
  localparam int PRE_SHIFT    = 3;
  localparam int QUOT_IN_W    = 13;
  localparam int RECIP_W      = 14;
  localparam logic [RECIP_W-1:0] RECIP_25 = 14'd10486;
  localparam int RECIP_SHIFT  = 18;
  localparam int RECIP_PROD_W = QUOT_IN_W + RECIP_W;

  localparam logic [7:0] PIXEL_ALPHA = 8'hff;

  // Tone curve entry: largest n <= 255 with n*n*7650000 <= 25599^2 * (4x - 102)
  function automatic logic [7:0] tone_entry(int unsigned x);
    longint unsigned num;
    longint unsigned rhs;
    logic [7:0]      best;
    best = 8'd0;
    if (4 * x <= 102) begin
      return 8'd0;
    end
    num = longint'(4 * x - 102);
    if (num > 765) begin
      num = 765;
    end
    rhs = 64'd25599 * 64'd25599 * num;
    for (int n = 0; n < 256; n++) begin
      if (longint'(n) * longint'(n) * 64'd7650000 <= rhs) begin
        best = 8'(n);
      end
    end
    return best;
  endfunction

endpackage

[hw/rtl/vrac_front.sv]
// Front end: accept samples, look up emission, derive opacity, push to queue.
module vrac_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vrac_pkg::VOXEL_W-1:0]  in_voxel,
  input  logic                          in_last,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [2*(FRAC_BITS+1):0]      push_data
);
  import vrac_pkg::*;

  localparam int AW = FRAC_BITS + 1;
  localparam int PW = 2 * AW;
  localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [AW-1:0] ALPHA_K = AW'(((3 << FRAC_BITS) + 50) / 100);

  typedef logic [AW-1:0] gtab_t [256];

  // Emission per raw sample: round(tone * ONE / 255)
  function automatic gtab_t build_gtab();
    gtab_t           t;
    longint unsigned v;
    for (int x = 0; x < 256; x++) begin
      v = (longint'(tone_entry(x)) * (longint'(1) << FRAC_BITS) + 127) / 255;
      t[x] = AW'(v);
    end
    return t;
  endfunction

  localparam gtab_t G_TAB = build_gtab();

  logic          st_valid_r;
  logic [AW-1:0] st_g_r;
  logic          st_last_r;
  logic [PW-1:0] a_prod;
  logic [PW:0]   a_round;
  logic [AW+1:0] a_full;
  logic [AW-1:0] a_val;

  assign in_ready   = !st_valid_r || push_ready;
  assign push_valid = st_valid_r;

  // Hold the looked-up emission until the queue takes the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_valid_r <= 1'b1;
    end else if (push_ready) begin
      st_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_g_r    <= G_TAB[in_voxel];
      st_last_r <= in_last;
    end
  end

  // Opacity a = round(g * A / ONE), capped at ONE
  always_comb begin
    a_prod  = PW'(st_g_r) * PW'(ALPHA_K);
    a_round = {1'b0, a_prod} + HALF;
    a_full  = a_round[PW:FRAC_BITS];
    if (a_full > (AW + 2)'(ONE)) begin
      a_val = ONE;
    end else begin
      a_val = a_full[AW-1:0];
    end
  end

  assign push_data = {st_last_r, a_val, st_g_r};

endmodule

[hw/rtl/vrac_fifo.sv]
// Short queue between the front end and the accumulator back end.
module vrac_fifo #(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import vrac_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/vrac_back.sv]
// Back end: accumulate each sample, then scale and emit the gray pixel at the end of a ray.
module vrac_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [2*(FRAC_BITS+1):0]     pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vrac_pkg::PIXEL_W-1:0] out_pixel
);
  import vrac_pkg::*;

  localparam int AW = FRAC_BITS + 1;
  localparam int PW = 2 * AW;
  localparam int SW = AW + 2;
  localparam int SP_W = SW + SCALE_W;
  localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [AW-1:0] ACC_MAX = {AW{1'b1}};
  localparam logic [SW-1:0] S_CAP = SW'(1) << (FRAC_BITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_RECIP = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           acc_r, acc_nxt;
  logic [PW-1:0]           prod1_r, prod1_nxt;
  logic [PW-1:0]           prod2_r, prod2_nxt;
  logic                    last_r, last_nxt;
  logic [SW-1:0]           s_r, s_nxt;
  logic [SP_W-1:0]         sp_r, sp_nxt;
  logic [RECIP_PROD_W-1:0] q_r, q_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]      out_pixel_r, out_pixel_nxt;

  logic [AW-1:0]           e_g;
  logic [AW-1:0]           e_a;
  logic                    e_last;
  logic [AW-1:0]           one_minus_a;
  logic [PW:0]             r1;
  logic [PW:0]             r2;
  logic [AW+2:0]           acc_sum;
  logic [AW-1:0]           acc_new;
  logic [SW-1:0]           triple;
  logic [QUOT_IN_W-1:0]    quot_in;
  logic [RECIP_PROD_W-RECIP_SHIFT-1:0] gray_raw;
  logic [GRAY_W-1:0]       gray;

  assign e_g    = pop_data[AW-1:0];
  assign e_a    = pop_data[2*AW-1:AW];
  assign e_last = pop_data[2*AW];

  assign pop_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  // Datapath helpers
  always_comb begin
    one_minus_a = ONE - e_a;
    r1      = {1'b0, prod1_r} + HALF;
    r2      = {1'b0, prod2_r} + HALF;
    acc_sum = (AW + 3)'(r1[PW:FRAC_BITS]) + (AW + 3)'(r2[PW:FRAC_BITS]);
    if (acc_sum > (AW + 3)'(ACC_MAX)) begin
      acc_new = ACC_MAX;
    end else begin
      acc_new = acc_sum[AW-1:0];
    end
    triple   = SW'(acc_new) * SW'(3);
    quot_in  = sp_r[FRAC_BITS+PRE_SHIFT+QUOT_IN_W-1:FRAC_BITS+PRE_SHIFT];
    gray_raw = q_r[RECIP_PROD_W-1:RECIP_SHIFT];
    if (gray_raw > (RECIP_PROD_W - RECIP_SHIFT)'(255)) begin
      gray = 8'hff;
    end else begin
      gray = gray_raw[GRAY_W-1:0];
    end
  end

  // Sequence accumulate, scale and output steps
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    prod1_nxt     = prod1_r;
    prod2_nxt     = prod2_r;
    last_nxt      = last_r;
    s_nxt         = s_r;
    sp_nxt        = sp_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          prod1_nxt = PW'(e_g) * PW'(e_a);
          prod2_nxt = PW'(acc_r) * PW'(one_minus_a);
          last_nxt  = e_last;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (last_r) begin
          s_nxt     = (triple > S_CAP) ? S_CAP : triple;
          acc_nxt   = '0;
          state_nxt = ST_SCALE;
        end else begin
          acc_nxt   = acc_new;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCALE: begin
        sp_nxt    = SP_W'(s_r) * SP_W'(GRAY_SCALE);
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        q_nxt     = RECIP_PROD_W'(quot_in) * RECIP_PROD_W'(RECIP_25);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = {PIXEL_ALPHA, gray, gray, gray};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r     <= prod1_nxt;
    prod2_r     <= prod2_nxt;
    last_r      <= last_nxt;
    s_r         <= s_nxt;
    sp_r        <= sp_nxt;
    q_r         <= q_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

endmodule

[hw/rtl/voxel_ray_alpha_compositor.sv]
// A sample passes the table register, the queue and the product registers before it is
// folded into the accumulator; the pixel follows the last sample through the scale,
// reciprocal and output registers. The back end takes a new sample only after the
// accumulator loop (multiply, then round, add and saturate) has finished the previous one;
// a last sample also holds it for scale multiply, reciprocal divide by 25, output register.
// Reset: synchronous active-low rst_n clears the accumulator, the queue and all valid
// flags; the tone table is constant logic and needs no fill.
module voxel_ray_alpha_compositor #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [vrac_pkg::VOXEL_W-1:0] in_tdata,   // [7:0] voxel
  input  logic                         in_tlast,   // last_of_ray
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [vrac_pkg::PIXEL_W-1:0] out_tdata   // [31:0] pixel
);
  import vrac_pkg::*;

  localparam int QW = 2 * (FRAC_BITS + 1) + 1;

  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  vrac_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_voxel   (in_tdata),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  vrac_fifo #(.WIDTH(QW)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  vrac_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata)
  );

endmodule
